// ----- rtl/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types, codes and helper functions for the tagged frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // default width of the frame length and byte counters
  localparam int unsigned DefLengthBits = 16;

  // register reset values
  localparam logic [15:0] MaxPayloadReset = 16'd1020;
  localparam logic [7:0]  FilterLowReset  = 8'h60;
  localparam logic [7:0]  FilterHighReset = 8'h80;

  // framing bytes
  localparam logic [7:0] TagByte   = 8'hFF;
  localparam logic [7:0] ShortLen  = 8'h55;
  localparam logic [7:0] LongLen   = 8'h56;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_FILTER_LOW  = 2'd1,
    CFG_FILTER_HIGH = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // receive phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TAG     = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  // end status
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_ZERO_LEN = 2'd3
  } err_e;

  // command groups
  typedef enum logic [2:0] {
    GRP_UART      = 3'd0,
    GRP_NET       = 3'd1,
    GRP_SYS       = 3'd2,
    GRP_USER      = 3'd3,
    GRP_MULTIROOM = 3'd4,
    GRP_EQ        = 3'd5,
    GRP_NONE      = 3'd6
  } grp_e;

  // configuration register set
  typedef struct packed {
    logic [15:0] max_payload;
    logic [7:0]  filter_low;
    logic [7:0]  filter_high;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic [2:0] cmd_group;
    logic       dispatch_ok;
    logic       frame_end;
    logic [1:0] error_code;
  } res_t;

  // group class of a command number
  function automatic grp_e group_of(input logic [7:0] c);
    grp_e g;
    if (c >= 8'h01 && c < 8'h20)      g = GRP_UART;
    else if (c > 8'h20 && c < 8'h40)  g = GRP_NET;
    else if (c > 8'h40 && c < 8'h60)  g = GRP_SYS;
    else if (c > 8'h60 && c < 8'h80)  g = GRP_USER;
    else if (c > 8'h80 && c < 8'h90)  g = GRP_MULTIROOM;
    else if (c > 8'h90 && c < 8'hAF)  g = GRP_EQ;
    else                              g = GRP_NONE;
    return g;
  endfunction

  // command may be dispatched when outside the held-back window
  function automatic logic dispatch_of(input logic [7:0] c, input logic [7:0] lo,
                                       input logic [7:0] hi);
    return !(c >= lo && c <= hi);
  endfunction

endpackage

// ----- rtl/tfd_core.sv -----
// ----------------------------------------------------------------------------
// tfd_core
// Per-byte frame state update and result formation, one byte per cycle while beat_i is high.
// ----------------------------------------------------------------------------
module tfd_core #(
  parameter int unsigned LENGTH_BITS = tfd_pkg::DefLengthBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    in_byte_i,
  input  tfd_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output tfd_pkg::res_t res_o
);

  localparam logic [15:0] LenLimit = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  tfd_pkg::phase_e        phase_q, phase_d;
  logic                   long_q, long_d;
  logic [7:0]             len_hi_q, len_hi_d;
  logic [LENGTH_BITS-1:0] frame_len_q, frame_len_d;
  logic [LENGTH_BITS-1:0] seen_q, seen_d;
  logic [7:0]             sum_q, sum_d;
  logic [7:0]             cmd_q, cmd_d;

  logic [15:0]            len_full;
  logic [LENGTH_BITS-1:0] seen_inc;
  logic [7:0]             sum_next;
  logic [7:0]             cmd_now;
  logic                   first;

  assign sum_next = sum_q + in_byte_i;
  assign seen_inc = seen_q + LENGTH_BITS'(1);
  assign len_full = long_q ? {len_hi_q, in_byte_i} : {8'h00, in_byte_i};
  assign first    = (seen_q == '0);
  assign cmd_now  = first ? in_byte_i : cmd_q;

  // next state and result for the current beat
  always_comb begin
    phase_d     = phase_q;
    long_d      = long_q;
    len_hi_d    = len_hi_q;
    frame_len_d = frame_len_q;
    seen_d      = seen_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      tfd_pkg::PH_TAG: begin
        if (in_byte_i == tfd_pkg::ShortLen || in_byte_i == tfd_pkg::LongLen) begin
          long_d      = (in_byte_i == tfd_pkg::LongLen);
          frame_len_d = '0;
          seen_d      = '0;
          sum_d       = '0;
          cmd_d       = '0;
          phase_d     = long_d ? tfd_pkg::PH_LEN_HI : tfd_pkg::PH_LEN_LO;
        end else if (in_byte_i != tfd_pkg::TagByte) begin
          phase_d = tfd_pkg::PH_HUNT;
        end
      end
      tfd_pkg::PH_LEN_HI: begin
        len_hi_d = in_byte_i;
        sum_d    = sum_next;
        phase_d  = tfd_pkg::PH_LEN_LO;
      end
      tfd_pkg::PH_LEN_LO: begin
        sum_d       = sum_next;
        frame_len_d = len_full[LENGTH_BITS-1:0];
        if (len_full == '0) begin
          phase_d           = tfd_pkg::PH_HUNT;
          res_valid_o       = 1'b1;
          res_o.cmd_group   = tfd_pkg::GRP_NONE;
          res_o.frame_end   = 1'b1;
          res_o.error_code  = tfd_pkg::ERR_ZERO_LEN;
        end else if (len_full > cfg_i.max_payload || len_full > LenLimit) begin
          phase_d           = tfd_pkg::PH_HUNT;
          res_valid_o       = 1'b1;
          res_o.cmd_group   = tfd_pkg::GRP_NONE;
          res_o.frame_end   = 1'b1;
          res_o.error_code  = tfd_pkg::ERR_TOO_LONG;
        end else begin
          phase_d = tfd_pkg::PH_PAYLOAD;
        end
      end
      tfd_pkg::PH_PAYLOAD: begin
        sum_d             = sum_next;
        cmd_d             = cmd_now;
        seen_d            = seen_inc;
        if (seen_inc >= frame_len_q) phase_d = tfd_pkg::PH_CHECK;
        res_valid_o       = 1'b1;
        res_o.out_byte    = in_byte_i;
        res_o.is_command  = first;
        res_o.cmd_group   = tfd_pkg::group_of(cmd_now);
        res_o.dispatch_ok = tfd_pkg::dispatch_of(cmd_now, cfg_i.filter_low,
                                                 cfg_i.filter_high);
        res_o.error_code  = tfd_pkg::ERR_NONE;
      end
      tfd_pkg::PH_CHECK: begin
        phase_d           = tfd_pkg::PH_HUNT;
        res_valid_o       = 1'b1;
        res_o.out_byte    = in_byte_i;
        res_o.cmd_group   = tfd_pkg::group_of(cmd_q);
        res_o.dispatch_ok = tfd_pkg::dispatch_of(cmd_q, cfg_i.filter_low,
                                                 cfg_i.filter_high);
        res_o.frame_end   = 1'b1;
        res_o.error_code  = (sum_next != 8'h00) ? tfd_pkg::ERR_CHECKSUM
                                                : tfd_pkg::ERR_NONE;
      end
      default: begin
        phase_d = (in_byte_i == tfd_pkg::TagByte) ? tfd_pkg::PH_TAG : tfd_pkg::PH_HUNT;
      end
    endcase
    if (!beat_i) res_valid_o = 1'b0;
  end

  // frame state, updated on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tfd_pkg::PH_HUNT;
      long_q      <= 1'b0;
      len_hi_q    <= '0;
      frame_len_q <= '0;
      seen_q      <= '0;
      sum_q       <= '0;
      cmd_q       <= '0;
    end else if (beat_i) begin
      phase_q     <= phase_d;
      long_q      <= long_d;
      len_hi_q    <= len_hi_d;
      frame_len_q <= frame_len_d;
      seen_q      <= seen_d;
      sum_q       <= sum_d;
      cmd_q       <= cmd_d;
    end
  end

endmodule

// ----- rtl/tfd_outbuf.sv -----
// ----------------------------------------------------------------------------
// tfd_outbuf
// Result register with a skid slot, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module tfd_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tfd_pkg::res_t push_data_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tfd_pkg::res_t out_data_o
);

  logic          main_valid_q, main_valid_d;
  logic          skid_valid_q, skid_valid_d;
  tfd_pkg::res_t main_q, main_d;
  tfd_pkg::res_t skid_q, skid_d;

  assign space_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // refill the output register from the skid slot first
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result data
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ----- rtl/tagged_frame_deframer_unit.sv -----
// A result beat is registered in the result buffer before it shows on the output.
// Throughput: one byte per cycle while the result buffer has space; frame state updates per byte.
// A two-entry result buffer keeps input flowing while one result is stalled.
// Reset: asynchronous, active low; hunts for the tag, empties the result buffer
// and loads max_payload 1020, filter_low 0x60, filter_high 0x80.
// ----------------------------------------------------------------------------
// tagged_frame_deframer_unit
// Tagged byte-stream deframer with length check, checksum and command class.
// ----------------------------------------------------------------------------
module tagged_frame_deframer_unit #(
  parameter int unsigned LENGTH_BITS = tfd_pkg::DefLengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_command_o,
  output logic [2:0]  cmd_group_o,
  output logic        dispatch_ok_o,
  output logic        frame_end_o,
  output logic [1:0]  error_code_o
);

  tfd_pkg::cfg_t cfg_q;
  tfd_pkg::res_t res;
  tfd_pkg::res_t out_data;
  logic          res_valid;
  logic          in_beat;

  assign cfg_ready_o = 1'b1;
  assign in_beat     = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= tfd_pkg::MaxPayloadReset;
      cfg_q.filter_low  <= tfd_pkg::FilterLowReset;
      cfg_q.filter_high <= tfd_pkg::FilterHighReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tfd_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i;
        tfd_pkg::CFG_FILTER_LOW:  cfg_q.filter_low  <= cfg_data_i[7:0];
        tfd_pkg::CFG_FILTER_HIGH: cfg_q.filter_high <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // frame state machine
  tfd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .in_byte_i   (in_byte_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffer
  tfd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign out_byte_o    = out_data.out_byte;
  assign is_command_o  = out_data.is_command;
  assign cmd_group_o   = out_data.cmd_group;
  assign dispatch_ok_o = out_data.dispatch_ok;
  assign frame_end_o   = out_data.frame_end;
  assign error_code_o  = out_data.error_code;

endmodule

// ----- rtl/tfd_checker.sv -----
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module tfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        is_command_o,
  input logic [2:0]  cmd_group_o,
  input logic        dispatch_ok_o,
  input logic        frame_end_o,
  input logic [1:0]  error_code_o
);

  // a stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_end_o) && $stable(error_code_o))
    else $error("result beat changed while stalled");

  // an end beat never carries the command flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> !is_command_o)
    else $error("command flag on frame end");

  // error codes only appear on end beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> error_code_o == tfd_pkg::ERR_NONE)
    else $error("error code outside frame end");

  // length errors carry an empty command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == tfd_pkg::ERR_TOO_LONG
      || error_code_o == tfd_pkg::ERR_ZERO_LEN)
    |-> out_byte_o == 8'h00 && cmd_group_o == tfd_pkg::GRP_NONE && !dispatch_ok_o)
    else $error("length error beat not cleared");

endmodule

bind tagged_frame_deframer_unit tfd_checker u_tfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .is_command_o  (is_command_o),
  .cmd_group_o   (cmd_group_o),
  .dispatch_ok_o (dispatch_ok_o),
  .frame_end_o   (frame_end_o),
  .error_code_o  (error_code_o)
);
